// ===== src/ps2mpd_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet decoder.
// Used by the packet assembler, the position accumulator and the top level.
`timescale 1ns / 1ps

package ps2mpd_pkg;

  // Field widths of one result item.
  localparam int unsigned PosW    = 32;
  localparam int unsigned ButtonW = 3;
  localparam int unsigned ByteW   = 8;

  // Bit positions inside the packet header byte.
  localparam int unsigned SyncBit = 3;
  localparam int unsigned XOvfBit = 6;
  localparam int unsigned YOvfBit = 7;

  // A completed packet, as seen by the accumulator in the cycle it closes.
  typedef struct packed {
    logic             done;       // this byte closes a packet
    logic             wheel_upd;  // fourth byte in wheel mode: load wheel
    logic [ByteW-1:0] head;       // header byte
    logic [ByteW-1:0] dx;         // signed X delta
    logic [ByteW-1:0] dy;         // signed Y delta
    logic [ByteW-1:0] wheel;      // signed wheel delta
  } pkt_t;

endpackage

// ===== src/ps2mpd_assembler.sv =====
// Packet assembler: tracks the byte position, keeps sync and holds the
// first three bytes of a packet. Depends on ps2mpd_pkg.
`timescale 1ns / 1ps

module ps2mpd_assembler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,          // one byte is consumed
  input  logic                           wheel_mode_i,
  input  logic [ps2mpd_pkg::ByteW-1:0]   rx_byte_i,
  output ps2mpd_pkg::pkt_t               pkt_o
);
  import ps2mpd_pkg::*;

  localparam logic [1:0] BytePos0 = 2'd0;
  localparam logic [1:0] BytePos1 = 2'd1;
  localparam logic [1:0] BytePos2 = 2'd2;
  localparam logic [1:0] BytePos3 = 2'd3;

  logic [1:0]       pos_q, pos_d;
  logic [ByteW-1:0] head_q, dx_q, dy_q;
  logic             drop;

  // A byte without the sync bit cannot start a packet.
  assign drop = (pos_q == BytePos0) && !rx_byte_i[SyncBit];

  // Packet completion and the fields handed to the accumulator.
  always_comb begin
    pkt_o.done      = (pos_q == BytePos3) || ((pos_q == BytePos2) && !wheel_mode_i);
    pkt_o.wheel_upd = (pos_q == BytePos3) && wheel_mode_i;
    pkt_o.head      = head_q;
    pkt_o.dx        = dx_q;
    pkt_o.dy        = (pos_q == BytePos2) ? rx_byte_i : dy_q;
    pkt_o.wheel     = rx_byte_i;
  end

  // Next byte position.
  always_comb begin
    pos_d = pos_q;
    if (en_i && !drop) begin
      if (pkt_o.done) begin
        pos_d = BytePos0;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= BytePos0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Held bytes of the packet in progress.
  always_ff @(posedge clk_i) begin
    if (en_i && !drop) begin
      case (pos_q)
        BytePos0: head_q <= rx_byte_i;
        BytePos1: dx_q   <= rx_byte_i;
        BytePos2: dy_q   <= rx_byte_i;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/ps2mpd_accum.sv =====
// Position accumulator: applies a completed packet to the stored position,
// buttons and wheel. Its registers are the result payload. Depends on ps2mpd_pkg.
`timescale 1ns / 1ps

module ps2mpd_accum (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,       // apply the packet
  input  ps2mpd_pkg::pkt_t                    pkt_i,
  output logic signed [ps2mpd_pkg::PosW-1:0]  pos_x_o,
  output logic signed [ps2mpd_pkg::PosW-1:0]  pos_y_o,
  output logic [ps2mpd_pkg::ButtonW-1:0]      button_bits_o,
  output logic signed [ps2mpd_pkg::ByteW-1:0] wheel_delta_o
);
  import ps2mpd_pkg::*;

  logic [PosW-1:0]    acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [ButtonW-1:0] buttons_q;
  logic [ByteW-1:0]   wheel_q, wheel_d;
  logic [PosW-1:0]    dx_ext, dy_ext;

  // Sign-extend the deltas to the position width.
  assign dx_ext = {{(PosW-ByteW){pkt_i.dx[ByteW-1]}}, pkt_i.dx};
  assign dy_ext = {{(PosW-ByteW){pkt_i.dy[ByteW-1]}}, pkt_i.dy};

  // Overflow flags in the header suppress the matching axis.
  always_comb begin
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    wheel_d = wheel_q;
    if (!pkt_i.head[XOvfBit]) begin
      acc_x_d = acc_x_q + dx_ext;
    end
    if (!pkt_i.head[YOvfBit]) begin
      acc_y_d = acc_y_q - dy_ext;
    end
    if (pkt_i.wheel_upd) begin
      wheel_d = pkt_i.wheel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q   <= '0;
      acc_y_q   <= '0;
      buttons_q <= '0;
      wheel_q   <= '0;
    end else if (en_i) begin
      acc_x_q   <= acc_x_d;
      acc_y_q   <= acc_y_d;
      buttons_q <= pkt_i.head[ButtonW-1:0];
      wheel_q   <= wheel_d;
    end
  end

  assign pos_x_o       = acc_x_q;
  assign pos_y_o       = acc_y_q;
  assign button_bits_o = buttons_q;
  assign wheel_delta_o = wheel_q;

endmodule

// ===== src/ps2_mouse_packet_decoder.sv =====
// Top level of the PS/2 mouse packet decoder: input register, handshakes,
// wheel mode register. Depends on ps2mpd_pkg, ps2mpd_assembler, ps2mpd_accum.
//
//   Channel   Direction  Payload
//   s_axis    in         rx_byte, one received mouse byte
//   m_axis    out        pos_x, pos_y, button_bits, wheel_delta per packet
//   cfg       in         wheel_mode (1 bit), write only
//
// One byte is taken per cycle unless a pending result stalls it. In the input
// register the assembler and accumulator act on a byte in a single pass; a closing
// byte loads the result register, which is the accumulator state itself.
// Reset clears the position, buttons, wheel, byte position and wheel mode.
// A result not yet taken stalls the input register only when the next byte
// there would close a packet of its own.
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Received bytes: [7:0] rx_byte.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // Results: [31:0] pos_x, [63:32] pos_y, [66:64] button_bits,
  // [74:67] wheel_delta, [79:75] zero.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,
  // Wheel mode register.
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);
  import ps2mpd_pkg::*;

  logic                    wheel_mode_q;
  logic                    in_valid_q;
  logic [ByteW-1:0]        in_byte_q;
  logic                    out_valid_q;
  logic                    proc;
  pkt_t                    pkt;
  logic signed [PosW-1:0]  pos_x, pos_y;
  logic [ButtonW-1:0]      button_bits;
  logic signed [ByteW-1:0] wheel_delta;

  // Wheel mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      wheel_mode_q <= cfg_wdata_i;
    end
  end

  // The held byte is consumed unless it closes a packet while the
  // result register still holds an item not yet taken.
  assign proc          = in_valid_q && (!pkt.done || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  ps2mpd_assembler u_assembler (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (proc),
    .wheel_mode_i (wheel_mode_q),
    .rx_byte_i    (in_byte_q),
    .pkt_o        (pkt)
  );

  ps2mpd_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (proc && pkt.done),
    .pkt_i         (pkt),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y),
    .button_bits_o (button_bits),
    .wheel_delta_o (wheel_delta)
  );

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && pkt.done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, wheel_delta, button_bits, pos_y, pos_x};

  // A consumed closing byte always produces a result next cycle.
  a_done_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && pkt.done) |=> out_valid_q)
    else $error("completed packet did not raise a result");

  // A held byte that is not consumed stays in the input register.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("unconsumed input byte was lost");

  // The wheel is loaded only by a byte that closes a packet.
  a_wheel_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && pkt.wheel_upd) |-> pkt.done)
    else $error("wheel update outside packet completion");

  // A result still waiting is never overwritten by a new packet.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && in_valid_q && pkt.done) |-> !proc)
    else $error("pending result overwritten");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the PS/2 mouse packet decoder: directed packets, then
// random byte streams under several handshake pressures. Depends on ps2mpd_pkg
// and on the ps2_mouse_packet_decoder top level with its submodules.
`timescale 1ns / 1ps

module tb;

  import ps2mpd_pkg::*;

  // Result layout on m_axis_tdata, lowest field first.
  localparam int unsigned YLsb    = PosW;
  localparam int unsigned BtnLsb  = 2 * PosW;
  localparam int unsigned WhlLsb  = BtnLsb + ButtonW;
  localparam int unsigned PadLsb  = WhlLsb + ByteW;
  localparam int unsigned ResultW = 80;

  // A byte is decoded while it sits in the input register; wait DrainCycles
  // more before touching the mode register.
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned SegmentLen  = 190;

  // One decoded mouse state, as carried by a result item.
  typedef struct packed {
    logic [PosW-1:0]    pos_x;
    logic [PosW-1:0]    pos_y;
    logic [ButtonW-1:0] buttons;
    logic [ByteW-1:0]   wheel;
  } mouse_result_t;

  // Tracks packet framing and the accumulated mouse state, and holds the
  // states that the decoder still owes.
  class mouse_scoreboard;
    bit                 wheel_mode;
    logic [1:0]         byte_idx;
    logic [ByteW-1:0]   pkt_bytes [3];
    logic [PosW-1:0]    acc_x;
    logic [PosW-1:0]    acc_y;
    logic [ButtonW-1:0] buttons;
    logic [ByteW-1:0]   wheel;
    mouse_result_t      expected_q [$];
    int unsigned        errors;

    function new();
      wheel_mode = 1'b0;
      byte_idx   = '0;
      acc_x      = '0;
      acc_y      = '0;
      buttons    = '0;
      wheel      = '0;
      errors     = 0;
      for (int i = 0; i < 3; i++) pkt_bytes[i] = '0;
    endfunction

    // Account for one byte taken by the decoder.
    function void note_byte(logic [ByteW-1:0] rx);
      logic [PosW-1:0] dx;
      logic [PosW-1:0] dy;
      bit              closes;
      // While waiting for a header, a byte without the sync bit is dropped.
      if (byte_idx == 2'd0 && !rx[SyncBit]) return;
      if (byte_idx != 2'd3) pkt_bytes[byte_idx] = rx;
      closes = (byte_idx == 2'd3) || (byte_idx == 2'd2 && !wheel_mode);
      if (!closes) begin
        byte_idx = byte_idx + 2'd1;
        return;
      end
      dx = {{(PosW-ByteW){pkt_bytes[1][ByteW-1]}}, pkt_bytes[1]};
      dy = {{(PosW-ByteW){pkt_bytes[2][ByteW-1]}}, pkt_bytes[2]};
      if (!pkt_bytes[0][XOvfBit]) acc_x = acc_x + dx;
      if (!pkt_bytes[0][YOvfBit]) acc_y = acc_y - dy;
      buttons = pkt_bytes[0][ButtonW-1:0];
      // Only a fourth byte closing in wheel mode loads the wheel.
      if (byte_idx == 2'd3 && wheel_mode) wheel = rx;
      byte_idx = '0;
      expected_q.push_back('{acc_x, acc_y, buttons, wheel});
    endfunction

    task flag_error(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_field(string name, logic [PosW-1:0] got, logic [PosW-1:0] want);
      if (got !== want)
        flag_error($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Compare one result item with the oldest owed state.
    task check_result(logic [ResultW-1:0] data);
      mouse_result_t want;
      if (expected_q.size() == 0) begin
        flag_error($sformatf("result %h with nothing pending", data));
        return;
      end
      want = expected_q.pop_front();
      check_field("pos_x", data[YLsb-1:0], want.pos_x);
      check_field("pos_y", data[BtnLsb-1:YLsb], want.pos_y);
      check_field("button_bits", PosW'(data[WhlLsb-1:BtnLsb]), PosW'(want.buttons));
      check_field("wheel_delta", PosW'(data[PadLsb-1:WhlLsb]), PosW'(want.wheel));
      check_field("padding", PosW'(data[ResultW-1:PadLsb]), '0);
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ResultW-1:0] m_axis_tdata;
  logic               cfg_we_i;
  logic               cfg_wdata_i;

  mouse_scoreboard    sb = new();
  int unsigned        send_idle_pct  = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        quiet_cycles   = 0;
  bit                 cur_mode       = 1'b0;

  ps2_mouse_packet_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: random back-pressure set at the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checking at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles first. Entered and left just
  // after a falling edge.
  task automatic send_byte(input logic [7:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = rx;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_byte(rx);
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every owed result has come out.
  task automatic drain_block();
    s_axis_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Mode changes happen only with the decoder idle, possibly mid-packet.
  task automatic write_wheel_mode(input bit mode);
    drain_block();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = mode;
    @(negedge clk_i);
    cfg_we_i       = 1'b0;
    sb.wheel_mode  = mode;
    cur_mode       = mode;
  endtask

  // Mostly framed packets with random content, some noise bytes and some
  // truncated packets that knock the framing off.
  task automatic run_segment(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned plen;
    logic [7:0]  hdr;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(99) < 8) begin
        send_byte(8'($urandom_range(255)));
        sent += 1;
      end else begin
        plen = cur_mode ? 4 : 3;
        if ($urandom_range(99) < 5) plen = $urandom_range(plen - 1, 1);
        hdr          = 8'($urandom_range(255));
        hdr[SyncBit] = 1'b1;
        send_byte(hdr);
        for (int i = 1; i < plen; i++) send_byte(8'($urandom_range(255)));
        sent += plen;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Bytes without the sync bit while waiting for a header are dropped.
    send_byte(8'h00);
    send_byte(8'hF7);
    // Largest positive X step, most negative Y step, no buttons.
    send_byte(8'h08);
    send_byte(8'h7F);
    send_byte(8'h80);
    // Both overflow flags: position holds, every button pressed.
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    // X overflow only.
    send_byte(8'h4D);
    send_byte(8'h01);
    send_byte(8'hFF);
    // Wheel mode turned on after two bytes: the packet closes on its fourth.
    send_byte(8'h8A);
    send_byte(8'h10);
    write_wheel_mode(1'b1);
    send_byte(8'h20);
    send_byte(8'h80);
    // Full wheel packet with no motion and the largest wheel step.
    send_byte(8'h09);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h7F);
    // Wheel mode turned off with three bytes held: the fourth byte still
    // closes the packet, and the wheel keeps its value.
    send_byte(8'h0B);
    send_byte(8'h05);
    send_byte(8'h06);
    write_wheel_mode(1'b0);
    send_byte(8'h55);
    // Wheel mode turned off with two bytes held: the third byte closes it.
    write_wheel_mode(1'b1);
    send_byte(8'h8C);
    send_byte(8'h03);
    write_wheel_mode(1'b0);
    send_byte(8'hFE);

    // Random traffic under each handshake pressure, both packet formats.
    for (int phase = 0; phase < 4; phase++) begin
      drain_block();
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 78;
        end
        default: begin
          send_idle_pct  = 19;
          recv_stall_pct = 19;
        end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        write_wheel_mode(seg[0] ^ phase[0]);
        run_segment(SegmentLen);
      end
    end

    drain_block();
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ps2mpd_pkg.sv
src/ps2mpd_assembler.sv
src/ps2mpd_accum.sv
src/ps2_mouse_packet_decoder.sv
bench/tb.sv
